@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define SPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define SPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ src/spr_pkg.sv @@
// Shared constants and types of the spike removal block.
package spr_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int THR_BITS        = 16;
    localparam int COUNT_BITS      = 16;
    localparam int FILL_BITS       = 3;

    typedef logic [THR_BITS-1:0]   t_thr;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [FILL_BITS-1:0]  t_fill;

    localparam t_thr   THR_RESET = {THR_BITS{1'b1}};
    localparam t_count COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam t_fill  FILL_FULL = t_fill'(5);

endpackage

@@ src/spr_spike_det.sv @@
// Spike test on three consecutive raw samples.
module spr_spike_det #(
    parameter int SAMPLE_BITS = spr_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] i_before,
    input  logic signed [SAMPLE_BITS-1:0] i_mid,
    input  logic signed [SAMPLE_BITS-1:0] i_after,
    input  spr_pkg::t_thr                 i_thr,
    output logic                          o_spike
);
    import spr_pkg::*;

    localparam int SW = SAMPLE_BITS;
    localparam int CW = (SW + 1 > THR_BITS) ? SW + 1 : THR_BITS;

    logic signed [SW:0] d_in;
    logic signed [SW:0] d_out;
    logic        [SW:0] a_in;
    logic        [SW:0] a_out;
    logic               opposite;

    assign d_in  = $signed({i_before[SW-1], i_before}) - $signed({i_mid[SW-1], i_mid});
    assign d_out = $signed({i_mid[SW-1], i_mid}) - $signed({i_after[SW-1], i_after});

    assign a_in  = d_in[SW]  ? $unsigned(-d_in)  : $unsigned(d_in);
    assign a_out = d_out[SW] ? $unsigned(-d_out) : $unsigned(d_out);

    // both steps non-zero and of opposite sign
    assign opposite = (d_in != '0) && (d_out != '0) && (d_in[SW] != d_out[SW]);

    assign o_spike = opposite
                   && (CW'(a_in)  > CW'(i_thr))
                   && (CW'(a_out) > CW'(i_thr));

endmodule

@@ src/spr_estimate.sv @@
// Replacement value for a spike: Lagrange estimate or neighbour mean.
module spr_estimate #(
    parameter int SAMPLE_BITS = spr_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] i_p1,
    input  logic signed [SAMPLE_BITS-1:0] i_p2,
    input  logic signed [SAMPLE_BITS-1:0] i_n1,
    input  logic signed [SAMPLE_BITS-1:0] i_n2,
    input  logic                          i_use_mean,
    output logic signed [SAMPLE_BITS-1:0] o_value
);
    import spr_pkg::*;

    localparam int SW = SAMPLE_BITS;
    localparam int NW = SW + 4;   // numerator 4*(p1+n1)-(p2+n2)
    localparam int MW = SW + 3;   // its magnitude
    localparam int HW = SW + 2;   // magnitude after the halving
    // floor(2^HW / 3); 2^HW is never a multiple of three
    localparam logic [HW-1:0] RECIP3 = {HW{1'b1}} / 3;
    localparam logic signed [HW:0] SMAX = {{(HW - SW + 2){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [HW:0] SMIN = ~SMAX;
    localparam logic [MW-1:0] RND_MEAN = MW'(1);
    localparam logic [MW-1:0] RND_SIX  = MW'(3);
    localparam logic [HW-1:0] THREE    = HW'(3);

    logic signed [SW:0]     sum_near;
    logic signed [SW:0]     sum_far;
    logic signed [NW-1:0]   num_six;
    logic signed [NW-1:0]   num;
    logic                   neg;
    logic        [NW-1:0]   mag_full;
    logic        [MW-1:0]   rounded;
    logic        [HW-1:0]   half;
    logic        [2*HW-1:0] prod;
    logic        [HW-1:0]   q_est;
    logic        [HW-1:0]   rem;
    logic        [HW-1:0]   q_six;
    logic        [HW-1:0]   q_sel;
    logic signed [HW:0]     s_val;

    assign sum_near = $signed({i_p1[SW-1], i_p1}) + $signed({i_n1[SW-1], i_n1});
    assign sum_far  = $signed({i_p2[SW-1], i_p2}) + $signed({i_n2[SW-1], i_n2});
    assign num_six  = (NW'(sum_near) <<< 2) - NW'(sum_far);
    assign num      = i_use_mean ? NW'(sum_near) : num_six;

    // round to nearest, ties away from zero, on the magnitude
    assign neg      = num[NW-1];
    assign mag_full = neg ? $unsigned(-num) : $unsigned(num);
    assign rounded  = mag_full[MW-1:0] + (i_use_mean ? RND_MEAN : RND_SIX);
    assign half     = rounded[MW-1:1];

    // divide by three: reciprocal estimate, then one correction step
    assign prod  = half * RECIP3;
    assign q_est = prod[2*HW-1:HW];
    assign rem   = half - (q_est << 1) - q_est;
    assign q_six = (rem >= THREE) ? q_est + HW'(1) : q_est;

    assign q_sel = i_use_mean ? half : q_six;
    assign s_val = neg ? -$signed({1'b0, q_sel}) : $signed({1'b0, q_sel});

    always_comb begin
        if (s_val > SMAX) begin
            o_value = SMAX[SW-1:0];
        end else if (s_val < SMIN) begin
            o_value = SMIN[SW-1:0];
        end else begin
            o_value = s_val[SW-1:0];
        end
    end

endmodule

@@ src/single_point_spike_removal.sv @@
// Top level of the single-point spike removal filter.
//
// Input channel i_valid/o_ready carries one signed sample per request. Output
// channel o_valid/i_ready carries one result per input request: the sample
// from three positions earlier, replaced by an interpolated value when it was
// a single-point spike, with o_out_valid, o_was_spike and o_spike_count.
// Each request passes through the input register, then the result register,
// before its result is presented on o_valid. Throughput: one request per cycle
// while i_ready is high, set by the single pass from the input register to the
// result register. The threshold is written through i_cfg_we/i_cfg_wdata, only
// while idle; the user must keep to this, as the block does not check it.
// Reset (synchronous, active low) clears the sample window, history, skip
// flag, fill level and spike count, empties both registers and sets the
// threshold to its maximum. When the receiver holds i_ready low the result
// register holds its request and one more request waits in the input
// register; o_ready then drops until the result is taken.
module single_point_spike_removal #(
    parameter int SAMPLE_BITS = spr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  spr_pkg::t_thr                 i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_out_valid,
    output logic                          o_was_spike,
    output spr_pkg::t_count               o_spike_count
);
    import spr_pkg::*;
    `include "assert_macros.svh"

    localparam int SW = SAMPLE_BITS;

    t_thr                 r_thr;
    logic                 r_in_vld;
    logic signed [SW-1:0] r_in_sample;
    logic                 r_out_vld;
    logic signed [SW-1:0] r_out_sample;
    logic                 r_out_full;
    logic                 r_out_spike;
    t_count               r_out_count;

    logic signed [SW-1:0] r_raw [0:3];
    logic signed [SW-1:0] r_hist [0:1];
    logic                 r_skip;
    t_fill                r_fill;
    t_count               r_spike_total;

    logic                 out_free;
    logic                 fire;
    t_fill                n_fill;
    logic                 full;
    logic                 spike_centre;
    logic                 spike_later;
    logic                 do_spike;
    logic signed [SW-1:0] est_value;
    logic signed [SW-1:0] n_result;
    logic                 n_skip;
    t_count               n_spike_total;

    assign out_free = !r_out_vld || i_ready;
    assign fire     = r_in_vld && out_free;
    assign o_ready  = !r_in_vld || fire;

    assign o_valid       = r_out_vld;
    assign o_sample_out  = r_out_sample;
    assign o_out_valid   = r_out_full;
    assign o_was_spike   = r_out_spike;
    assign o_spike_count = r_out_count;

    // window after this request: r_raw[0..3], then the registered sample
    spr_spike_det #(.SAMPLE_BITS(SAMPLE_BITS)) u_det_centre (
        .i_before (r_raw[0]),
        .i_mid    (r_raw[1]),
        .i_after  (r_raw[2]),
        .i_thr    (r_thr),
        .o_spike  (spike_centre)
    );

    spr_spike_det #(.SAMPLE_BITS(SAMPLE_BITS)) u_det_later (
        .i_before (r_raw[2]),
        .i_mid    (r_raw[3]),
        .i_after  (r_in_sample),
        .i_thr    (r_thr),
        .o_spike  (spike_later)
    );

    spr_estimate #(.SAMPLE_BITS(SAMPLE_BITS)) u_estimate (
        .i_p1       (r_hist[0]),
        .i_p2       (r_hist[1]),
        .i_n1       (r_raw[2]),
        .i_n2       (r_raw[3]),
        .i_use_mean (spike_later),
        .o_value    (est_value)
    );

    always_comb begin
        n_fill        = (r_fill < FILL_FULL) ? r_fill + t_fill'(1) : r_fill;
        full          = (n_fill == FILL_FULL);
        do_spike      = full && !r_skip && spike_centre;
        n_result      = do_spike ? est_value : r_raw[1];
        n_skip        = do_spike;
        n_spike_total = (do_spike && (r_spike_total != COUNT_MAX))
                      ? r_spike_total + t_count'(1) : r_spike_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_sample <= i_sample_in;
        end
    end

    // window, history and counters advance once per processed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw[0]      <= '0;
            r_raw[1]      <= '0;
            r_raw[2]      <= '0;
            r_raw[3]      <= '0;
            r_hist[0]     <= '0;
            r_hist[1]     <= '0;
            r_skip        <= 1'b0;
            r_fill        <= '0;
            r_spike_total <= '0;
        end else if (fire) begin
            r_raw[0]      <= r_raw[1];
            r_raw[1]      <= r_raw[2];
            r_raw[2]      <= r_raw[3];
            r_raw[3]      <= r_in_sample;
            r_hist[1]     <= r_hist[0];
            r_hist[0]     <= n_result;
            r_skip        <= n_skip;
            r_fill        <= n_fill;
            r_spike_total <= n_spike_total;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_sample <= n_result;
            r_out_full   <= full;
            r_out_spike  <= do_spike;
            r_out_count  <= n_spike_total;
        end
    end

    `SPR_ASSERT(a_spike_needs_full, (r_out_vld && r_out_spike) |-> r_out_full, "early spike flag")
    `SPR_ASSERT(a_skip_after_spike, (fire && do_spike) |=> r_skip, "skip flag not set")
    `SPR_ASSERT(a_no_back_to_back, (fire && r_skip) |-> !do_spike, "spike on a skipped sample")
    `SPR_ASSERT(a_count_holds, !fire |=> $stable(r_spike_total), "spike count moved while idle")

endmodule

@@ tb/single_point_spike_removal_tb.sv @@
// Self-checking testbench for the single-point spike removal filter.
`timescale 1ns / 1ps

module single_point_spike_removal_tb;

    localparam int SAMPLE_BITS = spr_pkg::SAMPLE_BITS_DEF;
    localparam int SAMPLE_MAX  = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam int CYCLE_LIMIT = 20_000;
    localparam int IDLE_PCT    = 23;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          out_valid;
        logic                          was_spike;
        spr_pkg::t_count               count;
    } t_despike_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    spr_pkg::t_thr                 cfg_wdata = '0;
    logic                          sample_valid = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic                          o_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic                          o_out_valid;
    logic                          o_was_spike;
    spr_pkg::t_count               o_spike_count;

    // Filter state mirrored by the predictor
    int  raw_win [5];
    int  corr_hist [2];
    bit  skip_pending;
    int  fill_level;
    int  spike_total;
    int  threshold_model;

    t_despike_result awaited_results[$];

    bit  idling_on = 1'b1;
    int  error_count;
    int  items_sent;
    int  results_checked;
    int  spikes_predicted;
    int  settings_used;
    int  cycle_count;

    single_point_spike_removal #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_valid      (sample_valid),
        .o_ready      (o_ready),
        .i_sample_in  (sample_in),
        .o_valid      (o_valid),
        .i_ready      (out_ready),
        .o_sample_out (o_sample_out),
        .o_out_valid  (o_out_valid),
        .o_was_spike  (o_was_spike),
        .o_spike_count(o_spike_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     awaited_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_ready <= !idling_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    function automatic int saturate_sample(input int v);
        if (v > SAMPLE_MAX) return SAMPLE_MAX;
        if (v < SAMPLE_MIN) return SAMPLE_MIN;
        return v;
    endfunction

    function automatic int abs_int(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Opposite-signed raw steps, both strictly above the threshold
    function automatic bit zigzag(input int before_s, input int mid_s, input int after_s);
        int d1;
        int d2;
        d1 = before_s - mid_s;
        d2 = mid_s - after_s;
        return ((d1 > 0 && d2 < 0) || (d1 < 0 && d2 > 0)) &&
               abs_int(d1) > threshold_model && abs_int(d2) > threshold_model;
    endfunction

    // Round to nearest, ties away from zero
    function automatic int round_half_away(input int num, input int den);
        int q;
        q = (abs_int(num) + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    task automatic reset_prediction;
        int k;
        for (k = 0; k < 5; k++) raw_win[k] = 0;
        corr_hist[0]    = 0;
        corr_hist[1]    = 0;
        skip_pending    = 1'b0;
        fill_level      = 0;
        spike_total     = 0;
        threshold_model = int'(spr_pkg::THR_RESET);
    endtask

    task automatic predict_despike(input logic signed [SAMPLE_BITS-1:0] value);
        t_despike_result res;
        int              k;
        int              outv;
        bit              hit;
        for (k = 0; k < 4; k++) raw_win[k] = raw_win[k + 1];
        raw_win[4] = int'(value);
        if (fill_level < int'(spr_pkg::FILL_FULL)) fill_level++;
        hit  = 1'b0;
        outv = raw_win[1];
        if (fill_level < int'(spr_pkg::FILL_FULL)) begin
            skip_pending = 1'b0;
        end else if (!skip_pending && zigzag(raw_win[0], raw_win[1], raw_win[2])) begin
            // a second spike two samples on forces the plain mean
            if (zigzag(raw_win[2], raw_win[3], raw_win[4]))
                outv = round_half_away(corr_hist[0] + raw_win[2], 2);
            else
                outv = round_half_away(4 * (corr_hist[0] + raw_win[2])
                                       - (corr_hist[1] + raw_win[3]), 6);
            outv         = saturate_sample(outv);
            hit          = 1'b1;
            skip_pending = 1'b1;
            spikes_predicted++;
            if (spike_total < int'(spr_pkg::COUNT_MAX)) spike_total++;
        end else begin
            skip_pending = 1'b0;
        end
        corr_hist[1] = corr_hist[0];
        corr_hist[0] = outv;
        res.sample    = outv[SAMPLE_BITS-1:0];
        res.out_valid = (fill_level >= int'(spr_pkg::FILL_FULL));
        res.was_spike = hit;
        res.count     = spike_total[spr_pkg::COUNT_BITS-1:0];
        awaited_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_despike_result exp_res;
        if (i_rst_n && o_valid && out_ready) begin
            if (awaited_results.size() == 0) begin
                error_count++;
                $error("unexpected result: sample_out %0d", o_sample_out);
            end else begin
                exp_res = awaited_results.pop_front();
                results_checked++;
                if (exp_res.sample !== o_sample_out) begin
                    error_count++;
                    $error("sample_out: expected %0d, got %0d", exp_res.sample,
                           o_sample_out);
                end
                if (exp_res.out_valid !== o_out_valid) begin
                    error_count++;
                    $error("out_valid: expected %0b, got %0b", exp_res.out_valid,
                           o_out_valid);
                end
                if (exp_res.was_spike !== o_was_spike) begin
                    error_count++;
                    $error("was_spike: expected %0b, got %0b", exp_res.was_spike,
                           o_was_spike);
                end
                if (exp_res.count !== o_spike_count) begin
                    error_count++;
                    $error("spike_count: expected %0d, got %0d", exp_res.count,
                           o_spike_count);
                end
            end
        end
    end

    // Values are wrapped to the sample width before they are driven
    task automatic send_sample(input int value);
        while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
            sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_valid <= 1'b1;
        sample_in    <= SAMPLE_BITS'(value);
        do @(posedge i_clk); while (!o_ready);
        predict_despike(SAMPLE_BITS'(value));
        items_sent++;
    endtask

    // Drop the request and wait for every outstanding result plus pipeline slack
    task automatic drain;
        sample_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(input spr_pkg::t_thr value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we          <= 1'b0;
        threshold_model = int'(value);
        settings_used++;
    endtask

    // Extremes at the reset threshold: a full-scale step equals it, so no spike
    task automatic test_window_fill_extremes;
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shffff);
        drain();
    endtask

    // Double spike takes the mean with a half tie, the next one the full estimate
    task automatic test_replacement_paths;
        write_threshold('0);
        send_sample(16'sd3);
        send_sample(16'sd3);
        send_sample(16'sd900);
        send_sample(16'sd0);
        send_sample(16'sd900);
        send_sample(16'sd0);
        send_sample(16'sd0);
        drain();
    endtask

    // Estimate overshoots full scale in both directions
    task automatic test_estimate_saturation;
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        drain();
    endtask

    function automatic int drift(input int base_v);
        int step;
        int delta;
        step  = ((threshold_model / 4 < 400) ? threshold_model / 4 : 400) + 2;
        delta = $urandom_range(0, 2 * step);
        base_v = base_v + delta - step;
        if (base_v > 30000) base_v = 30000;
        if (base_v < -30000) base_v = -30000;
        return base_v;
    endfunction

    task automatic send_episode(inout int baseline);
        int kind;
        int amp;
        int sgn;
        int n;
        kind = $urandom_range(0, 99);
        amp  = threshold_model + 1 + $urandom_range(0, 2000);
        sgn  = ($urandom_range(0, 1) == 1) ? 1 : -1;
        if (kind < 35) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                baseline = drift(baseline);
                send_sample(saturate_sample(baseline));
            end
        end else if (kind < 65) begin
            send_sample(saturate_sample(baseline + sgn * amp));
            send_sample(saturate_sample(baseline));
        end else if (kind < 80) begin
            send_sample(saturate_sample(baseline + sgn * amp));
            send_sample(saturate_sample(baseline));
            sgn = ($urandom_range(0, 1) == 1) ? 1 : -1;
            send_sample(saturate_sample(baseline + sgn * amp));
            send_sample(saturate_sample(baseline));
        end else if (kind < 90) begin
            // step right on the threshold or one above it
            amp = threshold_model + $urandom_range(0, 1);
            send_sample(saturate_sample(baseline + sgn * amp));
            send_sample(saturate_sample(baseline));
        end else begin
            n = $urandom_range(1, 3);
            repeat (n) send_sample($urandom);
        end
    endtask

    task automatic test_random_phases;
        spr_pkg::t_thr thr_set [5];
        int            phase;
        int            start_count;
        int            baseline;
        thr_set[0] = '0;
        thr_set[1] = spr_pkg::t_thr'($urandom_range(1, 255));
        thr_set[2] = spr_pkg::t_thr'($urandom_range(256, 20000));
        thr_set[3] = spr_pkg::t_thr'($urandom_range(30000, 50000));
        thr_set[4] = spr_pkg::THR_RESET;
        baseline = 0;
        for (phase = 0; phase < 5; phase++) begin
            write_threshold(thr_set[phase]);
            // one phase runs without any idling on either side
            idling_on   = (phase != 2);
            start_count = items_sent;
            while (items_sent - start_count < 90) send_episode(baseline);
            drain();
        end
        idling_on = 1'b1;
    endtask

    // Zigzag at zero threshold gives a spike every second sample, back to back
    task automatic test_alternating_spikes;
        int k;
        write_threshold('0);
        idling_on = 1'b0;
        for (k = 0; k < 16; k++) begin
            send_sample(0);
            send_sample($urandom_range(1, SAMPLE_MAX));
        end
        for (k = 0; k < 8; k++) begin
            send_sample(0);
            send_sample(-int'($urandom_range(1, SAMPLE_MAX)));
        end
        drain();
        idling_on = 1'b1;
    endtask

    initial begin
        reset_prediction();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_window_fill_extremes();
        test_replacement_paths();
        test_estimate_saturation();
        test_random_phases();
        test_alternating_spikes();

        drain();
        $display("Sent %0d samples across %0d threshold writes, %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("Spikes replaced: %0d (final count %0d).", spikes_predicted,
                 spike_total);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
